// ===== hdl/assert_macros.svh =====
// Assertion helpers; every use samples clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
// Next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hdl/htpp_pkg.sv =====
package htpp_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  typedef enum logic [3:0] {
    PH_NONE  = 4'b0001,
    PH_KEY   = 4'b0010,
    PH_SEP   = 4'b0100,
    PH_VALUE = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_VALUE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_BAD_ESC   = 3'd1,
    ERR_EQ_VALUE  = 3'd2,
    ERR_EQ_EARLY  = 3'd3,
    ERR_GT_UNQ    = 3'd4,
    ERR_GT_MISPL  = 3'd5,
    ERR_ESC_OUT   = 3'd6
  } err_t;

  typedef struct packed {
    phase_t phase;
    logic   in_quotes;
    logic   escape_pending;
    logic   error_hold;
  } state_t;

  typedef struct packed {
    logic [7:0] ch;
    kind_t      kind;
    logic       done;
    err_t       err;
  } res_t;

  localparam state_t ST_RESET = '{
    phase:          PH_NONE,
    in_quotes:      1'b0,
    escape_pending: 1'b0,
    error_hold:     1'b0
  };

endpackage

// ===== hdl/hstore_text_pair_parser_top.sv =====
// Path: an accepted byte waits in the input register, and its result in the result register.
// Throughput: one byte per cycle unless out_tready stalls; the parse state updates as a byte
// leaves the input register for a free result register; out_tready stalls both registers.
// Reset: synchronous, active-low rst_n; empties both registers and returns the parser
// to before-key, unquoted, with no pending escape or held error.
`include "assert_macros.svh"

module hstore_text_pair_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [4:0] out_tuser,  // [1:0] out_kind, [4:2] error_code
  output logic       out_tlast   // pair_end
);

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;
  logic             out_valid_r;
  htpp_pkg::res_t   out_res_r;
  htpp_pkg::state_t st_r;
  htpp_pkg::state_t st_nxt;
  htpp_pkg::res_t   res_nxt;
  logic             out_free;
  logic             s1_adv;
  logic             in_acc;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  htpp_step u_step (
    .st_i   (st_r),
    .byte_i (s1_byte_r),
    .last_i (s1_last_r),
    .st_o   (st_nxt),
    .res_o  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= htpp_pkg::ST_RESET;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.ch;
  assign out_tuser  = {out_res_r.err, out_res_r.kind};
  assign out_tlast  = out_res_r.done;

  `ASSERT_IMP(a_err_quiet, out_valid_r && out_res_r.err != htpp_pkg::ERR_OK, out_res_r.kind == htpp_pkg::KIND_NONE && !out_res_r.done)
  `ASSERT_IMP(a_nochar_zero, out_valid_r && out_res_r.kind == htpp_pkg::KIND_NONE, out_res_r.ch == 8'h00)
  `ASSERT_NXT(a_hold_silent, s1_adv && st_r.error_hold, out_res_r.err == htpp_pkg::ERR_OK && out_res_r.kind == htpp_pkg::KIND_NONE && !out_res_r.done)
  `ASSERT_NXT(a_last_clears, s1_adv && s1_last_r, st_r == htpp_pkg::ST_RESET)
  `ASSERT_NXT(a_s1_holds, s1_valid_r && !s1_adv, s1_valid_r)

endmodule

// ===== hdl/htpp_step.sv =====
module htpp_step (
  input  htpp_pkg::state_t st_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output htpp_pkg::state_t st_o,
  output htpp_pkg::res_t   res_o
);

  htpp_pkg::phase_t ph;
  htpp_pkg::phase_t ph_n;
  htpp_pkg::state_t nx;
  htpp_pkg::err_t   err;
  logic             field;
  logic             q;
  logic             emit;
  logic             done;

  always_comb begin
    unique case (st_i.phase)
      htpp_pkg::PH_KEY, htpp_pkg::PH_SEP, htpp_pkg::PH_VALUE: ph = st_i.phase;
      default: ph = htpp_pkg::PH_NONE;
    endcase
  end

  assign field = (ph == htpp_pkg::PH_KEY) || (ph == htpp_pkg::PH_VALUE);
  assign q     = st_i.in_quotes;

  always_comb begin
    nx    = st_i;
    ph_n  = ph;
    err   = htpp_pkg::ERR_OK;
    emit  = 1'b0;
    done  = 1'b0;
    res_o = '{ch: 8'h00, kind: htpp_pkg::KIND_NONE, done: 1'b0, err: htpp_pkg::ERR_OK};
    if (st_i.error_hold) begin
      // drop bytes until the string ends
      if (last_i) begin
        nx = htpp_pkg::ST_RESET;
      end
    end else begin
      priority if (st_i.escape_pending) begin
        if (byte_i == htpp_pkg::CH_QUOTE || byte_i == htpp_pkg::CH_BSLASH) begin
          if (field) begin
            emit              = 1'b1;
            nx.escape_pending = 1'b0;
          end else begin
            err = htpp_pkg::ERR_ESC_OUT;
          end
        end else begin
          err = htpp_pkg::ERR_BAD_ESC;
        end
      end else if (byte_i == htpp_pkg::CH_BSLASH) begin
        nx.escape_pending = 1'b1;
      end else if (byte_i == htpp_pkg::CH_EQ) begin
        priority if (!q && ph == htpp_pkg::PH_KEY) begin
          ph_n = htpp_pkg::PH_SEP;
        end else if (!q && ph == htpp_pkg::PH_VALUE) begin
          err = htpp_pkg::ERR_EQ_VALUE;
        end else if (q && field) begin
          emit = 1'b1;
        end else if (ph == htpp_pkg::PH_NONE) begin
          err = htpp_pkg::ERR_EQ_EARLY;
        end else begin
          // ignore in the separator
        end
      end else if (byte_i == htpp_pkg::CH_GT) begin
        priority if (!q && field) begin
          err = htpp_pkg::ERR_GT_UNQ;
        end else if (q && field) begin
          emit = 1'b1;
        end else if (ph != htpp_pkg::PH_SEP) begin
          err = htpp_pkg::ERR_GT_MISPL;
        end else begin
          // ignore in the separator
        end
      end else if (byte_i == htpp_pkg::CH_QUOTE) begin
        if (field) begin
          nx.in_quotes = 1'b0;
          if (ph == htpp_pkg::PH_VALUE) begin
            done = 1'b1;
          end else begin
            ph_n = htpp_pkg::PH_SEP;
          end
        end else begin
          ph_n = (ph == htpp_pkg::PH_NONE) ? htpp_pkg::PH_KEY : htpp_pkg::PH_VALUE;
          nx.in_quotes = 1'b1;
        end
      end else if (byte_i == htpp_pkg::CH_SPACE || byte_i == htpp_pkg::CH_COMMA) begin
        if (field) begin
          priority if (q) begin
            emit = 1'b1;
          end else if (ph == htpp_pkg::PH_VALUE) begin
            done = 1'b1;
          end else begin
            ph_n = htpp_pkg::PH_SEP;
          end
        end
      end else begin
        // plain character opens a field where none is open
        if (!field) begin
          ph_n = (ph == htpp_pkg::PH_NONE) ? htpp_pkg::PH_KEY : htpp_pkg::PH_VALUE;
        end
        emit = 1'b1;
      end

      if (err != htpp_pkg::ERR_OK) begin
        nx = st_i;
        if (last_i) begin
          nx = htpp_pkg::ST_RESET;
        end else begin
          nx.error_hold = 1'b1;
        end
        res_o.err = err;
      end else begin
        if (done) begin
          ph_n              = htpp_pkg::PH_NONE;
          nx.in_quotes      = 1'b0;
          nx.escape_pending = 1'b0;
        end
        nx.phase = ph_n;
        if (last_i) begin
          done = 1'b1;
          nx   = htpp_pkg::ST_RESET;
        end
        res_o.done = done;
        if (emit) begin
          res_o.ch   = byte_i;
          res_o.kind = (ph_n == htpp_pkg::PH_KEY) ? htpp_pkg::KIND_KEY
                                                  : htpp_pkg::KIND_VALUE;
        end
      end
    end
  end

  assign st_o = nx;

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;  // [7:0] in_byte
  logic       in_tlast = 1'b0;   // last_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [7:0] out_char
  logic [4:0] out_tuser;         // [1:0] out_kind, [4:2] error_code
  logic       out_tlast;         // pair_end

  // Parser state as predicted from the accepted requests
  htpp_pkg::phase_t hs_phase;
  logic             hs_quoted;
  logic             hs_escape;
  logic             hs_hold;

  htpp_pkg::res_t parsed_q[$];
  int   fail_count = 0;
  int   mismatch_count = 0;
  int   bytes_sent = 0;
  bit   src_gaps = 1'b0;
  bit   sink_gaps = 1'b0;
  int   sink_hold = 0;

  hstore_text_pair_parser_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void clear_parse_state();
    hs_phase  = htpp_pkg::PH_NONE;
    hs_quoted = 1'b0;
    hs_escape = 1'b0;
    hs_hold   = 1'b0;
  endfunction

  function automatic htpp_pkg::kind_t field_kind(htpp_pkg::phase_t ph);
    return (ph == htpp_pkg::PH_KEY) ? htpp_pkg::KIND_KEY : htpp_pkg::KIND_VALUE;
  endfunction

  function automatic void append_byte(ref logic [7:0] txt[$], input logic [7:0] c);
    txt = {txt, c};
  endfunction

  function automatic htpp_pkg::res_t parse_byte(logic [7:0] c, logic last);
    htpp_pkg::res_t   r;
    htpp_pkg::phase_t ph;
    logic             fld;
    logic             q;
    logic             done_now;
    r = '{ch: 8'h00, kind: htpp_pkg::KIND_NONE, done: 1'b0, err: htpp_pkg::ERR_OK};
    if (hs_hold) begin
      if (last) clear_parse_state();
      return r;
    end
    ph = hs_phase;
    fld = (ph == htpp_pkg::PH_KEY) || (ph == htpp_pkg::PH_VALUE);
    q = hs_quoted;
    done_now = 1'b0;

    if (hs_escape) begin
      if (c == htpp_pkg::CH_QUOTE || c == htpp_pkg::CH_BSLASH) begin
        if (fld) begin
          r.ch = c;
          r.kind = field_kind(ph);
          hs_escape = 1'b0;
        end else begin
          r.err = htpp_pkg::ERR_ESC_OUT;
        end
      end else begin
        r.err = htpp_pkg::ERR_BAD_ESC;
      end
    end else if (c == htpp_pkg::CH_BSLASH) begin
      hs_escape = 1'b1;
    end else if (c == htpp_pkg::CH_EQ) begin
      if (!q && ph == htpp_pkg::PH_KEY) begin
        ph = htpp_pkg::PH_SEP;
      end else if (!q && ph == htpp_pkg::PH_VALUE) begin
        r.err = htpp_pkg::ERR_EQ_VALUE;
      end else if (q && fld) begin
        r.ch = c;
        r.kind = field_kind(ph);
      end else if (ph == htpp_pkg::PH_NONE) begin
        r.err = htpp_pkg::ERR_EQ_EARLY;
      end
    end else if (c == htpp_pkg::CH_GT) begin
      if (!q && fld) begin
        r.err = htpp_pkg::ERR_GT_UNQ;
      end else if (q && fld) begin
        r.ch = c;
        r.kind = field_kind(ph);
      end else if (ph != htpp_pkg::PH_SEP) begin
        r.err = htpp_pkg::ERR_GT_MISPL;
      end
    end else if (c == htpp_pkg::CH_QUOTE) begin
      if (fld) begin
        hs_quoted = 1'b0;
        if (ph == htpp_pkg::PH_VALUE) done_now = 1'b1;
        else ph = htpp_pkg::PH_SEP;
      end else begin
        if (ph == htpp_pkg::PH_NONE) ph = htpp_pkg::PH_KEY;
        else ph = htpp_pkg::PH_VALUE;
        hs_quoted = 1'b1;
      end
    end else if (c == htpp_pkg::CH_SPACE || c == htpp_pkg::CH_COMMA) begin
      if (fld) begin
        if (q) begin
          r.ch = c;
          r.kind = field_kind(ph);
        end else if (ph == htpp_pkg::PH_VALUE) begin
          done_now = 1'b1;
        end else begin
          ph = htpp_pkg::PH_SEP;
        end
      end
    end else begin
      if (!fld) begin
        if (ph == htpp_pkg::PH_NONE) ph = htpp_pkg::PH_KEY;
        else ph = htpp_pkg::PH_VALUE;
      end
      r.ch = c;
      r.kind = field_kind(ph);
    end

    if (r.err != htpp_pkg::ERR_OK) begin
      r.ch = 8'h00;
      r.kind = htpp_pkg::KIND_NONE;
      if (last) clear_parse_state();
      else hs_hold = 1'b1;
    end else begin
      if (done_now) begin
        ph = htpp_pkg::PH_NONE;
        hs_quoted = 1'b0;
        hs_escape = 1'b0;
      end
      hs_phase = ph;
      if (last) begin
        done_now = 1'b1;
        clear_parse_state();
      end
      r.done = done_now;
    end
    return r;
  endfunction

  // Offer one request; returns at the edge where it is taken, valid still high
  task automatic push_byte(logic [7:0] c, logic last);
    htpp_pkg::res_t r;
    if (src_gaps && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    r = parse_byte(c, last);
    parsed_q = {parsed_q, r};
    bytes_sent++;
  endtask

  task automatic source_rest();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_queue(ref logic [7:0] txt[$]);
    for (int i = 0; i < txt.size(); i++) push_byte(txt[i], i == txt.size() - 1);
  endtask

  function automatic bit is_special(logic [7:0] c);
    return c == htpp_pkg::CH_QUOTE || c == htpp_pkg::CH_BSLASH ||
           c == htpp_pkg::CH_EQ || c == htpp_pkg::CH_GT ||
           c == htpp_pkg::CH_SPACE || c == htpp_pkg::CH_COMMA;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_special(c));
    return c;
  endfunction

  function automatic logic [7:0] special_char();
    case ($urandom_range(0, 5))
      0: return htpp_pkg::CH_QUOTE;
      1: return htpp_pkg::CH_BSLASH;
      2: return htpp_pkg::CH_EQ;
      3: return htpp_pkg::CH_GT;
      4: return htpp_pkg::CH_SPACE;
      default: return htpp_pkg::CH_COMMA;
    endcase
  endfunction

  function automatic void add_field(ref logic [7:0] txt[$], input bit quoted);
    int n;
    int pick;
    n = quoted ? $urandom_range(0, 4) : $urandom_range(1, 4);
    if (quoted) append_byte(txt, htpp_pkg::CH_QUOTE);
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        append_byte(txt, htpp_pkg::CH_BSLASH);
        append_byte(txt, $urandom_range(0, 1) ? htpp_pkg::CH_QUOTE : htpp_pkg::CH_BSLASH);
      end else if (quoted && pick < 4) begin
        case ($urandom_range(0, 3))
          0: append_byte(txt, htpp_pkg::CH_SPACE);
          1: append_byte(txt, htpp_pkg::CH_COMMA);
          2: append_byte(txt, htpp_pkg::CH_EQ);
          default: append_byte(txt, htpp_pkg::CH_GT);
        endcase
      end else begin
        append_byte(txt, plain_char());
      end
    end
    if (quoted) append_byte(txt, htpp_pkg::CH_QUOTE);
  endfunction

  // Mostly well-formed pair lists, some with one byte spoiled, some pure noise
  function automatic void build_text(ref logic [7:0] txt[$]);
    int mode;
    int pairs;
    txt.delete();
    mode = $urandom_range(0, 99);
    if (mode >= 85) begin
      repeat ($urandom_range(1, 8))
        append_byte(txt, $urandom_range(0, 1) ? special_char() : 8'($urandom_range(0, 255)));
      return;
    end
    pairs = $urandom_range(1, 3);
    for (int p = 0; p < pairs; p++) begin
      if ($urandom_range(0, 3) == 0) append_byte(txt, htpp_pkg::CH_SPACE);
      add_field(txt, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) append_byte(txt, htpp_pkg::CH_SPACE);
      append_byte(txt, htpp_pkg::CH_EQ);
      append_byte(txt, htpp_pkg::CH_GT);
      if ($urandom_range(0, 1)) append_byte(txt, htpp_pkg::CH_SPACE);
      add_field(txt, 1'($urandom_range(0, 1)));
      if (p != pairs - 1) begin
        append_byte(txt, htpp_pkg::CH_COMMA);
        if ($urandom_range(0, 1)) append_byte(txt, htpp_pkg::CH_SPACE);
      end else if ($urandom_range(0, 1)) begin
        append_byte(txt, $urandom_range(0, 1) ? htpp_pkg::CH_COMMA : htpp_pkg::CH_SPACE);
      end
    end
    if (mode >= 70)
      txt[$urandom_range(0, txt.size() - 1)] = $urandom_range(0, 3) ? special_char() :
                                                8'($urandom_range(0, 255));
  endfunction

  task automatic send_random(int count);
    logic [7:0] txt[$];
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      build_text(txt);
      send_queue(txt);
    end
    source_rest();
  endtask

  // Extremes of the byte, ignored bytes, pair end and string end
  task automatic test_plain_pair();
    push_byte(8'h00, 1'b0);
    push_byte(htpp_pkg::CH_EQ, 1'b0);
    push_byte(htpp_pkg::CH_GT, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(htpp_pkg::CH_COMMA, 1'b0);
    push_byte(htpp_pkg::CH_SPACE, 1'b1);
    source_rest();
  endtask

  // Quoted key with '=', escaped quote and '>'; quoted value with space and comma
  task automatic test_quoted_fields();
    send_text("\"=\\\">\"=>\" ,\"");
    source_rest();
  endtask

  // One string per error code; '>x' also covers a held error ending the string
  task automatic test_errors();
    send_text("=");
    send_text(">x");
    send_text("\\a");
    send_text("\\\"");
    send_text("a>");
    send_text("a=b=");
    source_rest();
  endtask

  task automatic test_random_text();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    send_random(400);
  endtask

  task automatic test_full_rate();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    send_random(80);
  endtask

  // Hold the result side while requests keep coming, so the input stalls
  task automatic test_backpressure();
    src_gaps  = 1'b0;
    sink_gaps = 1'b1;
    @(negedge clk);
    sink_hold = 60;
    @(posedge clk);
    send_random(40);
  endtask

  // Result side: random stalls plus a counted hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (sink_hold != 0) begin
        out_tready <= 1'b0;
        sink_hold = sink_hold - 1;
      end else if (sink_gaps && $urandom_range(0, 99) < 25) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    htpp_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (parsed_q.size() == 0) begin
        fail_count++;
        $display("unexpected result: char=%h kind=%0d err=%0d end=%b",
                 out_tdata, out_tuser[1:0], out_tuser[4:2], out_tlast);
      end else begin
        want = parsed_q.pop_front();
        if (out_tdata !== want.ch || out_tuser[1:0] !== want.kind ||
            out_tlast !== want.done || out_tuser[4:2] !== want.err) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected char=%h kind=%0d err=%0d end=%b, ",
                      "got char=%h kind=%0d err=%0d end=%b"},
                     want.ch, want.kind, want.err, want.done,
                     out_tdata, out_tuser[1:0], out_tuser[4:2], out_tlast);
        end
      end
    end
  end

  initial begin
    int guard;
    clear_parse_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_pair();
    test_quoted_fields();
    test_errors();
    test_random_text();
    test_full_rate();
    test_backpressure();

    sink_gaps = 1'b0;
    guard = 0;
    while (parsed_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (parsed_q.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived", parsed_q.size());
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
